// ----- hdl/opfs_pkg.sv -----
// ----------------------------------------------------------------------------
// opfs_pkg
// shared types and constants of the opus packet frame splitter
// ----------------------------------------------------------------------------
`default_nettype none

package opfs_pkg;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_HDR2    = 4'd1,
        PH_AUSIZE  = 4'd2,
        PH_TRIM    = 4'd3,
        PH_EXTLEN  = 4'd4,
        PH_EXTSKIP = 4'd5,
        PH_TOC     = 4'd6,
        PH_SIZEA   = 4'd7,
        PH_SIZEB   = 4'd8,
        PH_COUNT   = 4'd9,
        PH_PAD     = 4'd10,
        PH_DATA    = 4'd11
    } phase_t;

    typedef enum logic [3:0] {
        S_BYTE    = 4'd0,
        S_FIN     = 4'd1,
        S_C2RD    = 4'd2,
        S_C2CHK   = 4'd3,
        S_SUMRD   = 4'd4,
        S_SUMACC  = 4'd5,
        S_SUMCHK  = 4'd6,
        S_DIV     = 4'd7,
        S_EMIT_RD = 4'd8,
        S_EMIT    = 4'd9,
        S_ERR     = 4'd10
    } seq_t;

    localparam logic [1:0] CODE_SINGLE = 2'd0;
    localparam logic [1:0] CODE_PAIR   = 2'd1;
    localparam logic [1:0] CODE_SIZED  = 2'd2;
    localparam logic [1:0] CODE_MULTI  = 2'd3;

    localparam logic [7:0] CTRL_FIRST  = 8'h7F;
    localparam logic [2:0] CTRL_TOP    = 3'b111;
    localparam logic [7:0] CHAIN_BYTE  = 8'hFF;
    localparam logic [7:0] SIZE_ESC    = 8'd252;
    localparam logic [7:0] PAD_STEP    = 8'd254;
    localparam logic [7:0] TOC_MASK    = 8'hFC;
    localparam int         SIZE_W      = 11;
    localparam int         SUM_W       = 17;

endpackage

`default_nettype wire

// ----- hdl/opfs_div.sv -----
// ----------------------------------------------------------------------------
// opfs_div
// restoring divider, one quotient bit per cycle, six-bit divisor
// ----------------------------------------------------------------------------
`default_nettype none

module opfs_div
    import opfs_pkg::*;
#(
    parameter int W = 17
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [5:0]   divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [5:0]        remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     quo_reg, quo_next;
    logic [6:0]       rem_reg, rem_next;
    logic [5:0]       dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [6:0]       shifted;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[5:0], quo_reg[W-1]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = shifted - {1'b0, dvs_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[5:0];

endmodule

`default_nettype wire

// ----- hdl/opus_packet_frame_splitter.sv -----
// ----------------------------------------------------------------------------
// opus_packet_frame_splitter
// byte parser: takes the packet bytes one at a time; at a packet end the sequencer runs
//   its checks (stored size for code 2, a sum over the stored sizes for vbr, the divider
//   for cbr), then emits each descriptor through a read and an emit state, or an error beat
// throughput: one byte per cycle inside a packet while the output beat is free to load (a pending beat needs m_tready)
// reset: synchronous active-low aresetn clears all control state
// ----------------------------------------------------------------------------
`default_nettype none

module opus_packet_frame_splitter
    import opfs_pkg::*;
#(
    parameter int BUFFER_BYTES  = 65536,
    parameter int MAX_FRAMES    = 48,
    parameter int MAX_VBR_FRAME = 1275
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // byte_value
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // toc_value, frame_offset, frame_length, frame_index, zero
    output logic             m_tuser,   // parse_error
    output logic             m_tlast    // packet_end
);

    localparam int POS_W = $clog2(BUFFER_BYTES) + 1;
    localparam int PADW  = POS_W + 8;
    localparam int AW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW    = ((POS_W > SUM_W) ? POS_W : SUM_W) + 1;

    typedef struct packed {
        phase_t           phase;
        logic [7:0]       toc;
        logic [PADW-1:0]  pad;
        logic [5:0]       sread;
        logic [7:0]       sfirst;
        logic [5:0]       ftot;
        logic             vbr;
        logic [POS_W-1:0] dstart;
    } body_t;

    typedef struct packed {
        body_t              st;
        logic               we;
        logic [5:0]         waddr;
        logic [SIZE_W-1:0]  wdata;
        logic               err;
    } body_r_t;

    function automatic body_r_t body_f(body_t s, logic [7:0] b, logic [POS_W-1:0] pos);
        body_r_t           o;
        logic              do_after;
        logic              do_enter;
        logic              do_store;
        logic [5:0]        sr1;
        logic [5:0]        want;
        logic [SIZE_W-1:0] sz;
        o        = '0;
        o.st     = s;
        o.waddr  = s.sread;
        do_after = 1'b0;
        do_enter = 1'b0;
        do_store = 1'b0;
        sz       = '0;
        sr1      = '0;
        want     = '0;
        case (s.phase)
            PH_TOC: begin
                o.st.toc   = b;
                o.st.pad   = '0;
                o.st.sread = '0;
                if (b[1:0] == CODE_SINGLE || b[1:0] == CODE_PAIR) begin
                    do_enter = 1'b1;
                end else if (b[1:0] == CODE_SIZED) begin
                    o.st.phase = PH_SIZEA;
                end else begin
                    o.st.phase = PH_COUNT;
                end
            end
            PH_SIZEA: begin
                if (b < SIZE_ESC) begin
                    do_store = 1'b1;
                    sz       = SIZE_W'(b);
                end else begin
                    o.st.sfirst = b;
                    o.st.phase  = PH_SIZEB;
                end
            end
            PH_SIZEB: begin
                do_store = 1'b1;
                sz       = SIZE_W'({b, 2'b00}) + SIZE_W'(s.sfirst);
            end
            PH_COUNT: begin
                o.st.ftot = b[5:0];
                o.st.vbr  = b[7];
                if (b[5:0] == 6'd0 || b[5:0] > 6'(MAX_FRAMES)) begin
                    o.err = 1'b1;
                end else if (b[6]) begin
                    o.st.phase = PH_PAD;
                end else begin
                    do_after = 1'b1;
                end
            end
            PH_PAD: begin
                if (b == CHAIN_BYTE) begin
                    o.st.pad = s.pad + PADW'(PAD_STEP);
                end else begin
                    o.st.pad = s.pad + PADW'(b);
                    do_after = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (do_store) begin
            o.we       = (s.sread < 6'(MAX_FRAMES));
            o.wdata    = sz;
            sr1        = s.sread + 6'd1;
            o.st.sread = sr1;
            want       = (s.toc[1:0] == CODE_SIZED) ? 6'd1 : s.ftot - 6'd1;
            if (sr1 >= want) begin
                do_enter = 1'b1;
            end else begin
                o.st.phase = PH_SIZEA;
            end
        end
        if (do_after) begin
            if (o.st.vbr && o.st.ftot > 6'd1) begin
                o.st.phase = PH_SIZEA;
            end else begin
                do_enter = 1'b1;
            end
        end
        if (do_enter) begin
            o.st.dstart = pos + POS_W'(1);
            o.st.phase  = PH_DATA;
        end
        return o;
    endfunction

    // byte parser state
    seq_t             state_reg, state_next;
    body_t            bs_reg, bs_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [PADW-1:0]  unit_reg, unit_next;
    logic             hdr_reg, hdr_next;
    logic [7:0]       hflags_reg, hflags_next;
    logic [POS_W-1:0] pstart_reg, pstart_next;
    logic             errl_reg, errl_next;

    // packet end sequencer
    logic [7:0]       ftoc_reg, ftoc_next;
    logic [POS_W-1:0] fds_reg, fds_next;
    logic [POS_W-1:0] fr_reg, fr_next;
    logic [5:0]       fcnt_reg, fcnt_next;
    logic             fvbr_reg, fvbr_next;
    logic [PADW-1:0]  fpad_reg, fpad_next;
    logic             flast_reg, flast_next;
    logic [5:0]       k_reg, k_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [POS_W-1:0] lena_reg, lena_next;
    logic [POS_W-1:0] lenb_reg, lenb_next;
    logic [5:0]       tot_reg, tot_next;
    logic [POS_W-1:0] off_reg, off_next;

    // output beat
    logic             mv_reg, mv_next;
    logic [7:0]       mtoc_reg, mtoc_next;
    logic [15:0]      moff_reg, moff_next;
    logic [15:0]      mlen_reg, mlen_next;
    logic [5:0]       midx_reg, midx_next;
    logic             merr_reg, merr_next;
    logic             mend_reg, mend_next;

    logic [SIZE_W-1:0] fsize_mem [MAX_FRAMES];
    logic [SIZE_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [5:0]        mem_waddr;
    logic [SIZE_W-1:0] mem_wdata;

    logic             acc;
    logic             out_free;
    logic             byte_fin;
    logic             div_start;
    logic             div_done;
    logic [POS_W-1:0] div_quot;
    logic [5:0]       div_rem;
    logic [POS_W-1:0] r_less_pad;
    logic [CW-1:0]    last_len;
    logic             c1_bad, c2_bad, pad_bad, sum_bad, vlast_bad, div_bad;
    logic             k_at_sum_end, k_at_tot_end;
    logic [CW-1:0]    cur_len;

    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == S_BYTE) && out_free;
    assign acc      = s_tvalid && s_tready;

    assign r_less_pad   = POS_W'(PADW'(fr_reg) - fpad_reg);
    assign last_len     = CW'(fr_reg) - CW'(sum_reg);
    assign c1_bad       = fr_reg[0];
    assign c2_bad       = CW'(rd_data_reg) > CW'(fr_reg);
    assign pad_bad      = fpad_reg > PADW'(fr_reg);
    assign sum_bad      = CW'(sum_reg) > CW'(fr_reg);
    assign vlast_bad    = last_len > CW'(MAX_VBR_FRAME);
    assign div_bad      = div_rem != 6'd0;
    assign k_at_sum_end = k_reg == fcnt_reg - 6'd1;
    assign k_at_tot_end = k_reg == tot_reg - 6'd1;
    assign div_start    = (state_reg == S_FIN) && (ftoc_reg[1:0] == CODE_MULTI)
                          && !fvbr_reg && !pad_bad;
    assign cur_len      = k_at_tot_end ? CW'(lenb_reg)
                          : ((ftoc_reg[1:0] == CODE_MULTI && fvbr_reg) ? CW'(rd_data_reg)
                          : CW'(lena_reg));

    opfs_div #(
        .W (POS_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (r_less_pad),
        .divisor   (fcnt_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_BYTE: begin
                if (acc && byte_fin) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                case (ftoc_reg[1:0])
                    CODE_SINGLE: state_next = S_EMIT_RD;
                    CODE_PAIR:   state_next = c1_bad ? S_ERR : S_EMIT_RD;
                    CODE_SIZED:  state_next = S_C2RD;
                    default: begin
                        if (pad_bad) begin
                            state_next = S_ERR;
                        end else if (fvbr_reg) begin
                            state_next = S_SUMRD;
                        end else begin
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_C2RD:   state_next = S_C2CHK;
            S_C2CHK:  state_next = c2_bad ? S_ERR : S_EMIT_RD;
            S_SUMRD:  state_next = k_at_sum_end ? S_SUMCHK : S_SUMACC;
            S_SUMACC: state_next = S_SUMRD;
            S_SUMCHK: state_next = (sum_bad || vlast_bad) ? S_ERR : S_EMIT_RD;
            S_DIV: begin
                if (div_done) begin
                    state_next = div_bad ? S_ERR : S_EMIT_RD;
                end
            end
            S_EMIT_RD: state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    state_next = k_at_tot_end ? S_BYTE : S_EMIT_RD;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    state_next = S_BYTE;
                end
            end
            default: state_next = S_BYTE;
        endcase
    end

    // datapath
    always_comb begin
        body_r_t          br;
        body_r_t          br2;
        body_t            st;
        logic             err;
        logic             eop;
        logic             go_ext;
        logic             go_fin;
        logic             restart;
        logic [PADW-1:0]  trims;
        logic [PADW-1:0]  unit_n;
        bs_next     = bs_reg;
        pos_next    = pos_reg;
        unit_next   = unit_reg;
        hdr_next    = hdr_reg;
        hflags_next = hflags_reg;
        pstart_next = pstart_reg;
        errl_next   = errl_reg;
        ftoc_next   = ftoc_reg;
        fds_next    = fds_reg;
        fr_next     = fr_reg;
        fcnt_next   = fcnt_reg;
        fvbr_next   = fvbr_reg;
        fpad_next   = fpad_reg;
        flast_next  = flast_reg;
        k_next      = k_reg;
        sum_next    = sum_reg;
        lena_next   = lena_reg;
        lenb_next   = lenb_reg;
        tot_next    = tot_reg;
        off_next    = off_reg;
        mv_next     = mv_reg && !m_tready;
        mtoc_next   = mtoc_reg;
        moff_next   = moff_reg;
        mlen_next   = mlen_reg;
        midx_next   = midx_reg;
        merr_next   = merr_reg;
        mend_next   = mend_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        byte_fin    = 1'b0;
        br          = '0;
        br2         = '0;
        st          = bs_reg;
        err         = 1'b0;
        eop         = 1'b0;
        go_ext      = 1'b0;
        go_fin      = 1'b0;
        restart     = 1'b0;
        trims       = '0;
        unit_n      = unit_reg;

        case (state_reg)
            S_BYTE: begin
                if (acc) begin
                    if (errl_reg) begin
                        restart = s_tlast;
                    end else if (pos_reg >= POS_W'(BUFFER_BYTES)) begin
                        err = 1'b1;
                    end else begin
                        pos_next = pos_reg + POS_W'(1);
                        case (bs_reg.phase)
                            PH_START: begin
                                st.toc      = s_tdata;
                                pstart_next = pos_reg;
                                st.phase    = PH_HDR2;
                                err         = s_tlast;
                            end
                            PH_HDR2: begin
                                if (s_tlast) begin
                                    err = 1'b1;
                                end else if (bs_reg.toc == CTRL_FIRST
                                             && s_tdata[7:5] == CTRL_TOP) begin
                                    hdr_next    = 1'b1;
                                    hflags_next = s_tdata;
                                    unit_n      = '0;
                                    st.phase    = PH_AUSIZE;
                                end else begin
                                    hdr_next  = 1'b0;
                                    st.phase  = PH_TOC;
                                    br        = body_f(st, bs_reg.toc, pstart_reg);
                                    br2       = body_f(br.st, s_tdata, pos_reg);
                                    st        = br2.st;
                                    mem_we    = br2.we;
                                    mem_waddr = br2.waddr;
                                    mem_wdata = br2.wdata;
                                    err       = br2.err;
                                end
                            end
                            PH_AUSIZE, PH_TRIM, PH_EXTLEN, PH_EXTSKIP: begin
                                case (bs_reg.phase)
                                    PH_AUSIZE: begin
                                        unit_n = unit_reg + PADW'(s_tdata);
                                        if (s_tdata != CHAIN_BYTE) begin
                                            trims = PADW'({hflags_reg[4], 1'b0})
                                                    + PADW'({hflags_reg[3], 1'b0});
                                            if (trims != '0) begin
                                                st.pad   = trims;
                                                st.phase = PH_TRIM;
                                            end else begin
                                                go_ext = 1'b1;
                                            end
                                        end
                                    end
                                    PH_TRIM: begin
                                        st.pad = bs_reg.pad - PADW'(1);
                                        go_ext = (st.pad == '0);
                                    end
                                    PH_EXTLEN: begin
                                        st.pad = PADW'(s_tdata);
                                        if (s_tdata != 8'd0) begin
                                            st.phase = PH_EXTSKIP;
                                        end else begin
                                            go_fin = 1'b1;
                                        end
                                    end
                                    default: begin
                                        st.pad = bs_reg.pad - PADW'(1);
                                        go_fin = (st.pad == '0);
                                    end
                                endcase
                                if (go_ext) begin
                                    if (hflags_reg[2]) begin
                                        st.phase = PH_EXTLEN;
                                    end else begin
                                        go_fin = 1'b1;
                                    end
                                end
                                if (go_fin) begin
                                    if (unit_n == '0) begin
                                        err = 1'b1;
                                    end else begin
                                        st.phase    = PH_TOC;
                                        pstart_next = pos_reg + POS_W'(1);
                                        st.pad      = '0;
                                    end
                                end
                                if (s_tlast) begin
                                    err = 1'b1;
                                end
                            end
                            default: begin
                                br        = body_f(bs_reg, s_tdata, pos_reg);
                                st        = br.st;
                                mem_we    = br.we;
                                mem_waddr = br.waddr;
                                mem_wdata = br.wdata;
                                err       = br.err;
                                if (!err) begin
                                    if (hdr_reg) begin
                                        unit_n = unit_reg - PADW'(1);
                                        if (unit_n == '0) begin
                                            eop = 1'b1;
                                        end else if (s_tlast) begin
                                            err = 1'b1;
                                        end
                                    end else if (s_tlast) begin
                                        eop = 1'b1;
                                    end
                                end
                            end
                        endcase
                        if (!err && eop) begin
                            if (st.phase != PH_DATA) begin
                                err = 1'b1;
                            end else begin
                                byte_fin   = 1'b1;
                                ftoc_next  = st.toc;
                                fds_next   = st.dstart;
                                fr_next    = pos_reg + POS_W'(1) - st.dstart;
                                fcnt_next  = st.ftot;
                                fvbr_next  = st.vbr;
                                fpad_next  = st.pad;
                                flast_next = s_tlast;
                                st.phase   = PH_START;
                            end
                        end
                    end
                    bs_next   = st;
                    unit_next = unit_n;
                    if (err) begin
                        mv_next   = 1'b1;
                        mtoc_next = '0;
                        moff_next = '0;
                        mlen_next = '0;
                        midx_next = '0;
                        merr_next = 1'b1;
                        mend_next = 1'b0;
                        if (!s_tlast) begin
                            errl_next = 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        restart = 1'b1;
                    end
                end
            end
            S_FIN: begin
                k_next   = '0;
                off_next = fds_reg;
                sum_next = '0;
                case (ftoc_reg[1:0])
                    CODE_SINGLE: begin
                        lenb_next = fr_reg;
                        tot_next  = 6'd1;
                    end
                    CODE_PAIR: begin
                        lena_next = fr_reg >> 1;
                        lenb_next = fr_reg >> 1;
                        tot_next  = 6'd2;
                    end
                    CODE_SIZED: begin
                    end
                    default: begin
                        fr_next = r_less_pad;
                    end
                endcase
            end
            S_C2CHK: begin
                lena_next = POS_W'(rd_data_reg);
                lenb_next = POS_W'(CW'(fr_reg) - CW'(rd_data_reg));
                tot_next  = 6'd2;
            end
            S_SUMACC: begin
                sum_next = sum_reg + SUM_W'(rd_data_reg);
                k_next   = k_reg + 6'd1;
            end
            S_SUMCHK: begin
                lenb_next = POS_W'(last_len);
                tot_next  = fcnt_reg;
                k_next    = '0;
            end
            S_DIV: begin
                if (div_done) begin
                    lena_next = div_quot;
                    lenb_next = div_quot;
                    tot_next  = fcnt_reg;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    mv_next   = 1'b1;
                    mtoc_next = ftoc_reg & TOC_MASK;
                    moff_next = 16'(off_reg);
                    mlen_next = 16'(cur_len);
                    midx_next = k_reg;
                    merr_next = 1'b0;
                    mend_next = k_at_tot_end;
                    off_next  = POS_W'(CW'(off_reg) + cur_len);
                    k_next    = k_reg + 6'd1;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    mv_next   = 1'b1;
                    mtoc_next = '0;
                    moff_next = '0;
                    mlen_next = '0;
                    midx_next = '0;
                    merr_next = 1'b1;
                    mend_next = 1'b0;
                    if (!flast_reg) begin
                        errl_next = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (restart) begin
            bs_next        = '0;
            bs_next.phase  = PH_START;
            pos_next       = '0;
            unit_next      = '0;
            hdr_next       = 1'b0;
            hflags_next    = '0;
            pstart_next    = '0;
            errl_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_BYTE;
            bs_reg        <= '0;
            pos_reg       <= '0;
            unit_reg      <= '0;
            hdr_reg       <= 1'b0;
            hflags_reg    <= '0;
            pstart_reg    <= '0;
            errl_reg      <= 1'b0;
            mv_reg        <= 1'b0;
        end else begin
            state_reg  <= state_next;
            bs_reg     <= bs_next;
            pos_reg    <= pos_next;
            unit_reg   <= unit_next;
            hdr_reg    <= hdr_next;
            hflags_reg <= hflags_next;
            pstart_reg <= pstart_next;
            errl_reg   <= errl_next;
            mv_reg     <= mv_next;
        end
        ftoc_reg  <= ftoc_next;
        fds_reg   <= fds_next;
        fr_reg    <= fr_next;
        fcnt_reg  <= fcnt_next;
        fvbr_reg  <= fvbr_next;
        fpad_reg  <= fpad_next;
        flast_reg <= flast_next;
        k_reg     <= k_next;
        sum_reg   <= sum_next;
        lena_reg  <= lena_next;
        lenb_reg  <= lenb_next;
        tot_reg   <= tot_next;
        off_reg   <= off_next;
        mtoc_reg  <= mtoc_next;
        moff_reg  <= moff_next;
        mlen_reg  <= mlen_next;
        midx_reg  <= midx_next;
        merr_reg  <= merr_next;
        mend_reg  <= mend_next;
    end

    // frame size store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            fsize_mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        rd_data_reg <= fsize_mem[k_reg[AW-1:0]];
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'b00, midx_reg, mlen_reg, moff_reg, mtoc_reg};
    assign m_tuser  = merr_reg;
    assign m_tlast  = mend_reg;

endmodule

`default_nettype wire
